@@ design/msc_pkg.sv @@
// shared types and constants for the mips subset core
package msc_pkg;
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TRAP_NEWLINE = 4'h0;
    localparam logic [3:0] TRAP_PRINT   = 4'h1;
    localparam logic [3:0] TRAP_READ    = 4'h5;
    localparam logic [3:0] TRAP_HALT    = 4'ha;

    localparam logic [1:0] PK_NONE    = 2'd0;
    localparam logic [1:0] PK_NEWLINE = 2'd1;
    localparam logic [1:0] PK_INT     = 2'd2;
    localparam logic [1:0] PK_PROMPT  = 2'd3;

    localparam logic [31:0] DATA_BASE   = 32'h1000_0000;
    localparam logic [31:0] GP_RESET    = 32'h1000_8000;
    localparam logic [31:0] START_RESET = 32'h0040_0000;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture instruction, read registers
        logic exec;     // decode and compute result
        logic mul_go;   // start multiply
        logic div_go;   // start divide
        logic div_step; // one restoring divide step
        logic commit;   // write state and present result
        logic stall_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mult;
        logic is_div;
        logic div_last;
        logic stopped;
    } sts_t;
endpackage

@@ design/msc_datapath.sv @@
// datapath: register file, hi/lo, data memory, alu, multiplier, divider
module msc_datapath #(
    parameter int DATA_WORDS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  msc_pkg::cmd_t       cmd,
    output msc_pkg::sts_t       sts,
    input  logic                cfg_write,
    input  logic [31:0]         cfg_data,
    input  logic [31:0]         instruction_word,
    input  logic signed [31:0]  console_value,
    output logic [31:0]         next_address,
    output logic                reg_written,
    output logic [4:0]          written_index,
    output logic [31:0]         written_value,
    output logic [1:0]          print_kind,
    output logic signed [31:0]  print_value,
    output logic                halted,
    output logic                unimplemented
);
    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [31:0] SP_RESET = msc_pkg::DATA_BASE + 32'(4 * DATA_WORDS);

    logic [31:0] pc_reg;
    logic [31:0] rf_reg [32];
    logic [31:0] hi_reg, lo_reg;
    logic        stop_reg;
    logic [31:0] mem [DATA_WORDS];
    logic [31:0] ins_reg, con_reg, a_reg, b_reg, mrd_reg;

    // execute results
    logic [31:0] npc_reg, wval_reg;
    logic        wr_reg, unimp_reg, halt_reg, memw_reg, hilo_reg;
    logic [4:0]  widx_reg;
    logic [1:0]  pk_reg;
    logic [31:0] pv_reg, mw_data_reg;
    logic [AW-1:0] mw_idx_reg;

    // multiply / divide
    logic [63:0] prod_reg;
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_q_reg, dneg_r_reg, dzero_reg;

    logic [5:0] op, fn;
    logic [4:0] rt, rd, sh;
    logic [31:0] simm, npc4, addr, off;
    logic        in_rng;
    assign op   = ins_reg[31:26];
    assign rt   = ins_reg[20:16];
    assign rd   = ins_reg[15:11];
    assign sh   = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign simm = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign npc4 = pc_reg + 32'd4;
    assign addr = a_reg + simm;
    assign off  = (addr - msc_pkg::DATA_BASE) >> 2;
    assign in_rng = (addr >= msc_pkg::DATA_BASE) && (off < 32'(DATA_WORDS));

    assign sts.is_mult  = (op == msc_pkg::OP_SPECIAL) && (fn == msc_pkg::FN_MULT);
    assign sts.is_div   = (op == msc_pkg::OP_SPECIAL) && (fn == msc_pkg::FN_DIV);
    assign sts.div_last = (dcnt_reg == 6'd31);
    assign sts.stopped  = stop_reg;

    // decode
    logic [31:0] e_npc, e_wval;
    logic        e_wr, e_unimp, e_halt, e_memw;
    logic [4:0]  e_widx;
    logic [1:0]  e_pk;
    logic [31:0] e_pv;
    always_comb
    begin
        e_npc = npc4; e_wval = 32'd0; e_wr = 1'b0; e_unimp = 1'b0;
        e_halt = 1'b0; e_memw = 1'b0; e_widx = 5'd0; e_pk = msc_pkg::PK_NONE;
        e_pv = 32'd0;
        unique case (op)
            msc_pkg::OP_SPECIAL:
            begin
                unique case (fn)
                    msc_pkg::FN_SLL:  begin e_wr = 1'b1; e_widx = rd; e_wval = b_reg << sh; end
                    msc_pkg::FN_SRA:
                    begin
                        e_wr = 1'b1; e_widx = rd;
                        e_wval = 32'($signed(b_reg) >>> sh);
                    end
                    msc_pkg::FN_JR:   e_npc = a_reg;
                    msc_pkg::FN_MFHI: begin e_wr = 1'b1; e_widx = rd; e_wval = hi_reg; end
                    msc_pkg::FN_MFLO: begin e_wr = 1'b1; e_widx = rd; e_wval = lo_reg; end
                    msc_pkg::FN_MULT, msc_pkg::FN_DIV: ;
                    msc_pkg::FN_ADDU: begin e_wr = 1'b1; e_widx = rd; e_wval = a_reg + b_reg; end
                    msc_pkg::FN_SUBU: begin e_wr = 1'b1; e_widx = rd; e_wval = a_reg - b_reg; end
                    msc_pkg::FN_SLT:
                    begin
                        e_wr = 1'b1; e_widx = rd;
                        e_wval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                    end
                    default: e_unimp = 1'b1;
                endcase
            end
            msc_pkg::OP_J:   e_npc = {npc4[31:28], ins_reg[25:0], 2'b00};
            msc_pkg::OP_JAL:
            begin
                e_wr = 1'b1; e_widx = 5'd31; e_wval = npc4;
                e_npc = {npc4[31:28], ins_reg[25:0], 2'b00};
            end
            msc_pkg::OP_BEQ: if (a_reg == b_reg) e_npc = npc4 + {simm[29:0], 2'b00};
            msc_pkg::OP_BNE: if (a_reg != b_reg) e_npc = npc4 + {simm[29:0], 2'b00};
            msc_pkg::OP_ADDIU: begin e_wr = 1'b1; e_widx = rt; e_wval = a_reg + simm; end
            msc_pkg::OP_ANDI:
            begin
                e_wr = 1'b1; e_widx = rt; e_wval = a_reg & {16'd0, ins_reg[15:0]};
            end
            msc_pkg::OP_LUI: begin e_wr = 1'b1; e_widx = rt; e_wval = {ins_reg[15:0], 16'd0}; end
            msc_pkg::OP_TRAP:
            begin
                unique case (ins_reg[3:0])
                    msc_pkg::TRAP_NEWLINE: e_pk = msc_pkg::PK_NEWLINE;
                    msc_pkg::TRAP_PRINT:   begin e_pk = msc_pkg::PK_INT; e_pv = a_reg; end
                    msc_pkg::TRAP_READ:
                    begin
                        e_pk = msc_pkg::PK_PROMPT; e_wr = 1'b1; e_widx = rt; e_wval = con_reg;
                    end
                    msc_pkg::TRAP_HALT: e_halt = 1'b1;
                    default: begin e_unimp = 1'b1; e_halt = 1'b1; end
                endcase
            end
            msc_pkg::OP_LW:
            begin
                e_wr = 1'b1; e_widx = rt; e_wval = in_rng ? mrd_reg : 32'd0;
            end
            msc_pkg::OP_SW: e_memw = in_rng;
            default: e_unimp = 1'b1;
        endcase
        if (e_widx == 5'd0)
        begin
            e_wr = 1'b0; e_wval = 32'd0;
        end
        if (!e_wr)
        begin
            e_widx = 5'd0; e_wval = 32'd0;
        end
    end

    // load cycle: capture and read; the memory read needs the address formed from
    // the captured a_reg, so mrd_reg is registered in the read state (on mul_go)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ins_reg <= instruction_word;
            con_reg <= console_value;
            a_reg   <= rf_reg[instruction_word[25:21]];
            b_reg   <= rf_reg[instruction_word[20:16]];
        end
        if (cmd.mul_go)
            mrd_reg <= mem[off[AW-1:0]];
        if (cmd.exec)
        begin
            npc_reg <= e_npc; wval_reg <= e_wval; wr_reg <= e_wr; widx_reg <= e_widx;
            unimp_reg <= e_unimp; halt_reg <= e_halt; memw_reg <= e_memw;
            pk_reg <= e_pk; pv_reg <= e_pv; mw_data_reg <= b_reg;
            mw_idx_reg <= off[AW-1:0];
            hilo_reg <= sts.is_mult || (sts.is_div && (b_reg != 32'd0));
        end
        if (cmd.commit && memw_reg)
            mem[mw_idx_reg] <= mw_data_reg;
    end

    // multiply in one registered stage, divide restoring one bit a cycle
    logic [31:0] ua, ub;
    logic [32:0] trial;
    assign ua = a_reg[31] ? 32'(-a_reg) : a_reg;
    assign ub = b_reg[31] ? 32'(-b_reg) : b_reg;
    assign trial = {dr_reg, dq_reg[31]} - {1'b0, dd_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            prod_reg <= $signed(a_reg) * $signed(b_reg);
        if (cmd.div_go)
        begin
            dq_reg <= ua; dr_reg <= 32'd0; dd_reg <= ub; dcnt_reg <= 6'd0;
            dneg_q_reg <= a_reg[31] ^ b_reg[31]; dneg_r_reg <= a_reg[31];
            dzero_reg <= (b_reg == 32'd0);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!trial[32])
            begin
                dr_reg <= trial[31:0]; dq_reg <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[30:0], dq_reg[31]}; dq_reg <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= msc_pkg::START_RESET;
            hi_reg <= 32'd0; lo_reg <= 32'd0; stop_reg <= 1'b0;
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= (i == 28) ? msc_pkg::GP_RESET :
                             (i == 29) ? SP_RESET : 32'd0;
            next_address <= 32'd0; reg_written <= 1'b0; written_index <= 5'd0;
            written_value <= 32'd0; print_kind <= 2'd0; print_value <= 32'sd0;
            halted <= 1'b0; unimplemented <= 1'b0;
        end
        else
        begin
            if (cfg_write) pc_reg <= cfg_data;
            if (cmd.stall_out)
            begin
                next_address <= pc_reg; reg_written <= 1'b0; written_index <= 5'd0;
                written_value <= 32'd0; print_kind <= 2'd0; print_value <= 32'sd0;
                halted <= 1'b1; unimplemented <= 1'b0;
            end
            else if (cmd.commit)
            begin
                pc_reg <= npc_reg;
                if (wr_reg) rf_reg[widx_reg] <= wval_reg;
                if (halt_reg) stop_reg <= 1'b1;
                if (hilo_reg && sts.is_mult)
                begin
                    hi_reg <= prod_reg[63:32]; lo_reg <= prod_reg[31:0];
                end
                else if (hilo_reg && !dzero_reg)
                begin
                    lo_reg <= dneg_q_reg ? 32'(-dq_reg) : dq_reg;
                    hi_reg <= dneg_r_reg ? 32'(-dr_reg) : dr_reg;
                end
                next_address <= npc_reg; reg_written <= wr_reg; written_index <= widx_reg;
                written_value <= wval_reg; print_kind <= pk_reg; print_value <= pv_reg;
                halted <= halt_reg; unimplemented <= unimp_reg;
            end
        end
    end
endmodule

@@ design/msc_control.sv @@
// controller: sequences load, execute, multiply/divide and commit
module msc_control (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          cfg_ready,
    input  logic          cfg_valid,
    output logic          cfg_write,
    output msc_pkg::cmd_t cmd,
    input  msc_pkg::sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       take, slot_free;

    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign take      = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                if (take)
                begin
                    cmd.load = 1'b1;
                    state_next = S_READ;
                end
            S_READ:
            begin
                // memory read and multiply use the captured operands
                cmd.mul_go = 1'b1;
                cmd.div_go = 1'b1;
                state_next = sts.is_div ? S_DIV : S_EXEC;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
                if (slot_free)
                begin
                    if (sts.stopped) cmd.stall_out = 1'b1;
                    else cmd.commit = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

@@ design/mips_subset_core_step.sv @@
// top level of the mips subset core
// Usage: one instruction word (and console value) per input transaction on
// in_valid/in_stall; one result per instruction on out_valid/out_stall.
// Sequence: each instruction passes load, operand-read, execute and commit in
// turn; div adds the steps of its one-bit-per-cycle restoring divider between
// operand-read and execute. The block works on one instruction at a time and
// accepts no new instruction until the current one has committed.
// The result sits in an output register; the next instruction is accepted
// while it waits, but its own commit waits until that result is taken.
// cfg_data is written on cfg_valid/cfg_ready while idle and goes straight into
// the pc. At reset the pc is 0x00400000, registers are zero except gp and
// sp, hi/lo are zero; data memory is undefined until stored.
// After halt every instruction returns pc unchanged with halted set.
module mips_subset_core_step #(
    parameter int DATA_WORDS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instruction_word,
    input  logic signed [31:0] console_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        next_address,
    output logic               reg_written,
    output logic [4:0]         written_index,
    output logic [31:0]        written_value,
    output logic [1:0]         print_kind,
    output logic signed [31:0] print_value,
    output logic               halted,
    output logic               unimplemented,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    msc_pkg::cmd_t cmd;
    msc_pkg::sts_t sts;
    logic          cfg_write;

    msc_control u_ctl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
        .cfg_ready, .cfg_valid, .cfg_write, .cmd, .sts
    );

    msc_datapath #(.DATA_WORDS(DATA_WORDS)) u_dp (
        .clk, .rst_n, .cmd, .sts, .cfg_write, .cfg_data,
        .instruction_word, .console_value, .next_address, .reg_written,
        .written_index, .written_value, .print_kind, .print_value,
        .halted, .unimplemented
    );
endmodule

@@ design/msc_checker.sv @@
// port-level checks for the mips subset core
module msc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        cfg_ready,
    input logic        reg_written,
    input logic [4:0]  written_index,
    input logic [31:0] next_address
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_address))
        else $error("stalled result changed");
    a_r0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_written |-> written_index != 5'd0)
        else $error("write to r0 reported");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("accepted while busy");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !in_valid || in_stall)
        else $error("two transactions back to back");
endmodule

bind mips_subset_core_step msc_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cfg_ready, .reg_written, .written_index, .next_address
);
